>>> rtl/core/pets_pkg.sv
// ----------------------------------------------------------------------------
// Periodic event timer scheduler package
// Shared constants, operation codes, word types and sequencer states.
// ----------------------------------------------------------------------------
package pets_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int FIFO_DEPTH = 16;
  localparam int TIME_WIDTH = 16;
  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_START   = 4'd1,
    OP_STOP    = 4'd2,
    OP_TICK    = 4'd3,
    OP_GET     = 4'd4,
    OP_PUT     = 4'd5,
    OP_SETPRIO = 4'd6,
    OP_MODIFY  = 4'd7,
    OP_JMODIFY = 4'd8,
    OP_RESTART = 4'd9,
    OP_SLEEP   = 4'd10,
    OP_RESUME  = 4'd11
  } op_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  timer_id;
    logic [15:0] new_period;
    logic [4:0]  new_priority;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic       event_found;
    logic [4:0] event_out;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/periodic_event_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// Periodic event timer scheduler
// Channel   Direction  Word         Handshake
// in        input      in_word_t    in_valid / in_stall
// out       output     out_word_t   out_valid / out_stall
// Single-entry ops pass from accept through the walk and finish states to the
// result. Tick, get, create, sleep and resume walk the table one entry per
// cycle through one shared update unit. Reset clears the whole table at once.
// A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
module periodic_event_timer_scheduler_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pets_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pets_pkg::out_word_t out_data
);
  import pets_pkg::*;

  logic [NUM_TIMERS-1:0] created, running, pending, saved;
  logic [TIME_WIDTH-1:0] counts [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] periods [NUM_TIMERS];
  logic [4:0] prios [NUM_TIMERS];

  state_t state, state_next;
  in_word_t cmd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] best;
  logic [4:0] top;
  logic walk_bad;
  out_word_t res;

  logic bad;
  logic [IDX_W-1:0] x;
  logic last;
  logic [TIME_WIDTH-1:0] cnt_inc;
  logic fire;
  logic fifo_push, fifo_pop, fifo_flush, fifo_ne;
  logic [4:0] push_id, head_id;

  assign bad = (cmd.timer_id == 8'd0) || (32'(cmd.timer_id) > NUM_TIMERS);
  assign x = IDX_W'(cmd.timer_id - 8'd1);
  assign last = (32'(idx) == NUM_TIMERS - 1);
  assign cnt_inc = counts[idx] + 1'b1;
  assign fire = (cnt_inc >= periods[idx]);

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fifo_push = 1'b0;
    fifo_pop = 1'b0;
    fifo_flush = 1'b0;
    push_id = 5'(32'(idx) + 1);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        case (op_t'(cmd.op))
          OP_TICK: begin
            if (created[idx]) begin
              fifo_push = running[idx] && fire && (prios[idx] == 5'd0);
              if (last) begin
                state_next = ST_FINISH;
              end
            end else begin
              state_next = ST_FINISH;
            end
          end
          OP_GET, OP_CREATE, OP_SLEEP, OP_RESUME: begin
            fifo_flush = (op_t'(cmd.op) == OP_SLEEP);
            if (!created[idx] || last || (op_t'(cmd.op) == OP_CREATE
                && (bad || idx >= x))) begin
              state_next = ST_FINISH;
            end
          end
          OP_PUT: begin
            push_id = cmd.timer_id[4:0];
            fifo_push = !bad && (prios[x] == 5'd0);
            state_next = ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_FINISH: begin
        fifo_pop = (op_t'(cmd.op) == OP_GET) && (top == 5'd0);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      created <= '0;
      running <= '0;
      pending <= '0;
      saved <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        counts[i] <= '0;
        periods[i] <= '0;
        prios[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd <= in_data;
            idx <= '0;
            top <= '0;
            best <= '0;
            walk_bad <= 1'b0;
          end
        end
        ST_WALK: begin
          idx <= idx + 1'b1;
          case (op_t'(cmd.op))
            OP_TICK: begin
              if (created[idx] && running[idx]) begin
                counts[idx] <= fire ? '0 : cnt_inc;
                if (fire && prios[idx] != 5'd0) begin
                  pending[idx] <= 1'b1;
                end
              end
            end
            OP_GET: begin
              if (created[idx] && pending[idx] && prios[idx] > top) begin
                top <= prios[idx];
                best <= idx;
              end
            end
            OP_CREATE: begin
              if (!bad && idx < x && !created[idx]) begin
                walk_bad <= 1'b1;
              end
            end
            OP_SLEEP: begin
              if (created[idx]) begin
                counts[idx] <= '0;
                pending[idx] <= 1'b0;
                saved[idx] <= running[idx];
                running[idx] <= 1'b0;
              end
            end
            OP_RESUME: begin
              if (created[idx]) begin
                running[idx] <= saved[idx];
                saved[idx] <= 1'b0;
              end
            end
            default: begin
              if (!bad) begin
                case (op_t'(cmd.op))
                  OP_START: running[x] <= 1'b1;
                  OP_STOP: begin
                    running[x] <= 1'b0;
                    counts[x] <= '0;
                  end
                  OP_PUT: begin
                    if (prios[x] != 5'd0) begin
                      pending[x] <= 1'b1;
                    end
                  end
                  OP_SETPRIO: prios[x] <= cmd.new_priority;
                  OP_MODIFY: begin
                    counts[x] <= '0;
                    periods[x] <= TIME_WIDTH'(cmd.new_period);
                  end
                  OP_JMODIFY: periods[x] <= TIME_WIDTH'(cmd.new_period);
                  OP_RESTART: begin
                    counts[x] <= '0;
                    running[x] <= 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
        ST_FINISH: begin
          res.status <= 1'b0;
          res.event_found <= 1'b0;
          res.event_out <= '0;
          case (op_t'(cmd.op))
            OP_CREATE: begin
              if (bad || walk_bad) begin
                res.status <= 1'b1;
              end else begin
                created[x] <= 1'b1;
                periods[x] <= TIME_WIDTH'(cmd.new_period);
                prios[x] <= '0;
              end
            end
            OP_GET: begin
              if (top != 5'd0) begin
                pending[best] <= 1'b0;
                res.event_found <= 1'b1;
                res.event_out <= 5'(32'(best) + 1);
              end else if (fifo_ne) begin
                res.event_found <= 1'b1;
                res.event_out <= head_id;
              end
            end
            OP_TICK, OP_SLEEP, OP_RESUME: begin
            end
            OP_START, OP_STOP, OP_PUT, OP_SETPRIO, OP_MODIFY, OP_JMODIFY,
            OP_RESTART: begin
              res.status <= bad;
            end
            default: begin
              res.status <= 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  pets_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(fifo_push),
    .push_id(push_id),
    .pop(fifo_pop),
    .flush(fifo_flush),
    .not_empty(fifo_ne),
    .head_id(head_id)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_found |-> out_data.event_out != 5'd0)
    else $error("found flag without id");
`endif
endmodule

>>> rtl/core/pets_fifo.sv
// ----------------------------------------------------------------------------
// Periodic event timer scheduler id queue
// Circular queue of event ids with a fill count; a push when full is dropped.
// ----------------------------------------------------------------------------
module pets_fifo (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [4:0] push_id,
  input  logic       pop,
  input  logic       flush,
  output logic       not_empty,
  output logic [4:0] head_id
);
  import pets_pkg::*;

  logic [4:0] mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] head;
  logic [FPTR_W-1:0] tail;
  logic [FCNT_W-1:0] count;

  function automatic logic [FPTR_W-1:0] inc(input logic [FPTR_W-1:0] p);
    if (32'(p) == FIFO_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign not_empty = (count != '0);
  assign head_id = mem[head];

  always_ff @(posedge clk) begin
    if (push && (32'(count) < FIFO_DEPTH)) begin
      mem[tail] <= push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push && (32'(count) < FIFO_DEPTH)) begin
        tail <= inc(tail);
        count <= count + 1'b1;
      end else if (pop && not_empty) begin
        head <= inc(head);
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= FIFO_DEPTH) else $error("queue count overflow");
  a_flush: assert property (@(posedge clk) flush && !rst |=> count == '0)
    else $error("flush left entries");
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    pop && !push && !flush && not_empty |=> count == $past(count) - 1'b1)
    else $error("pop did not decrement");
`endif
endmodule

>>> tb/sv/periodic_event_timer_scheduler_checker.sv
// ----------------------------------------------------------------------------
// Timer scheduler result checker
// Watches both channels, keeps its own copy of the timer table and the id
// FIFO, works out the result of every accepted word and compares it.
// ----------------------------------------------------------------------------
module periodic_event_timer_scheduler_checker
  import pets_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending_results,
  output int        found_count
);

  logic                  created [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] count_q [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] period_q [NUM_TIMERS];
  logic [4:0]            prio_q [NUM_TIMERS];
  logic                  running [NUM_TIMERS];
  logic                  pending [NUM_TIMERS];
  logic                  saved [NUM_TIMERS];
  logic [4:0]            id_fifo [$];
  out_word_t             result_queue [$];

  assign pending_results = result_queue.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void push_id(input logic [4:0] id);
    if (id_fifo.size() < FIFO_DEPTH) id_fifo.push_back(id);
  endfunction

  function automatic out_word_t schedule_step(input in_word_t w);
    out_word_t r;
    logic bad;
    int x;
    int best;
    logic [4:0] top;
    r = '0;
    bad = (w.timer_id == 0) || (w.timer_id > NUM_TIMERS);
    x = bad ? 0 : w.timer_id - 1;
    best = 0;
    top = 0;
    case (w.op)
      OP_CREATE: begin
        if (bad) r.status = 1'b1;
        else begin
          for (int i = 0; i < x; i++) if (!created[i]) r.status = 1'b1;
          if (!r.status) begin
            created[x] = 1'b1;
            period_q[x] = w.new_period;
            prio_q[x] = '0;
          end
        end
      end
      OP_START: if (bad) r.status = 1'b1; else running[x] = 1'b1;
      OP_STOP: begin
        if (bad) r.status = 1'b1;
        else begin
          running[x] = 1'b0;
          count_q[x] = '0;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!created[i]) break;
          if (running[i]) begin
            count_q[i] = count_q[i] + 1'b1;
            if (count_q[i] >= period_q[i]) begin
              count_q[i] = '0;
              if (prio_q[i] == 0) push_id(5'(i + 1));
              else pending[i] = 1'b1;
            end
          end
        end
      end
      OP_GET: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!created[i]) break;
          if (pending[i] && prio_q[i] > top) begin
            top = prio_q[i];
            best = i;
          end
        end
        if (top != 0) begin
          pending[best] = 1'b0;
          r.event_out = 5'(best + 1);
        end else if (id_fifo.size() > 0) begin
          r.event_out = id_fifo.pop_front();
        end
        r.event_found = (r.event_out != 0);
      end
      OP_PUT: begin
        if (bad) r.status = 1'b1;
        else if (prio_q[x] > 0) pending[x] = 1'b1;
        else push_id(5'(w.timer_id));
      end
      OP_SETPRIO: if (bad) r.status = 1'b1; else prio_q[x] = w.new_priority;
      OP_MODIFY: begin
        if (bad) r.status = 1'b1;
        else begin
          count_q[x] = '0;
          period_q[x] = w.new_period;
        end
      end
      OP_JMODIFY: if (bad) r.status = 1'b1; else period_q[x] = w.new_period;
      OP_RESTART: begin
        if (bad) r.status = 1'b1;
        else begin
          count_q[x] = '0;
          running[x] = 1'b1;
        end
      end
      OP_SLEEP: begin
        id_fifo.delete();
        for (int i = 0; i < NUM_TIMERS && created[i]; i++) begin
          count_q[i] = '0;
          pending[i] = 1'b0;
          saved[i] = running[i];
          running[i] = 1'b0;
        end
      end
      OP_RESUME: begin
        for (int i = 0; i < NUM_TIMERS && created[i]; i++) begin
          running[i] = saved[i];
          saved[i] = 1'b0;
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        created[i] = 0; count_q[i] = 0; period_q[i] = 0; prio_q[i] = 0;
        running[i] = 0; pending[i] = 0; saved[i] = 0;
      end
      id_fifo.delete();
      result_queue.delete();
      fail_count = 0;
      found_count = 0;
    end else begin
      if (in_valid && !in_stall) result_queue.push_back(schedule_step(in_data));
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch("result word with no expectation");
        end else begin
          e = result_queue.pop_front();
          if (e.event_found) found_count++;
          if (out_data.status !== e.status)
            report_mismatch($sformatf("status %b, expected %b", out_data.status, e.status));
          if (out_data.event_found !== e.event_found)
            report_mismatch($sformatf("event_found %b, expected %b",
                                      out_data.event_found, e.event_found));
          if (out_data.event_out !== e.event_out)
            report_mismatch($sformatf("event_out %0d, expected %0d",
                                      out_data.event_out, e.event_out));
        end
      end
    end
  end

endmodule

>>> tb/sv/periodic_event_timer_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// Timer scheduler testbench
// Drives directed and random operation words with random idle and stall
// bursts; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_event_timer_scheduler_top_tb;
  import pets_pkg::*;

  localparam int RANDOM_WORDS = 1900;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending_results;
  int        found_count;
  int        cycle_count = 0;
  int        sent_count = 0;
  logic      calm = 1'b0;

  always #5 clk = ~clk;

  periodic_event_timer_scheduler_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  periodic_event_timer_scheduler_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_results(pending_results),
    .found_count(found_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    int burst;
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (burst > 0) begin
      burst--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      burst = $urandom_range(0, 2);
    end
  end

  task automatic send_word(input logic [3:0] op, input logic [7:0] id,
                           input logic [15:0] per, input logic [4:0] pri);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {op, id, per, pri};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1: return 8'd0;
      default: return 8'($urandom_range(1, NUM_TIMERS));
    endcase
  endfunction

  task automatic random_word();
    logic [3:0] op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_TICK;
    else if (r < 50) op = OP_GET;
    else if (r < 53) op = OP_SLEEP;
    else if (r < 56) op = OP_RESUME;
    else if (r < 58) op = 4'($urandom_range(12, 15));
    else op = 4'($urandom_range(0, 11));
    send_word(op, pick_id(), pick_period(), 5'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_word(OP_CREATE, 8'd2, 16'd1, 5'd0);
    send_word(OP_CREATE, 8'd0, 16'd1, 5'd0);
    send_word(OP_CREATE, 8'd255, 16'd1, 5'd0);
    send_word(OP_START, 8'd5, 16'd0, 5'd0);
    send_word(OP_GET, 8'd0, 16'd0, 5'd0);
    for (int i = 1; i <= NUM_TIMERS; i++)
      send_word(OP_CREATE, 8'(i), (i == 1) ? 16'hFFFF : 16'(i % 3), 5'd0);
    send_word(OP_SETPRIO, 8'd3, 16'd0, 5'd31);
    send_word(OP_START, 8'd1, 16'd0, 5'd0);
    send_word(OP_RESTART, 8'd3, 16'd0, 5'd0);
    send_word(OP_TICK, 8'd0, 16'd0, 5'd0);
    send_word(OP_GET, 8'd0, 16'd0, 5'd0);
    send_word(OP_PUT, 8'd16, 16'd0, 5'd0);
    send_word(OP_MODIFY, 8'd1, 16'd0, 5'd0);
    send_word(OP_JMODIFY, 8'd2, 16'hFFFF, 5'd0);
    send_word(OP_STOP, 8'd3, 16'd0, 5'd0);
    send_word(OP_SLEEP, 8'd0, 16'd0, 5'd0);
    send_word(OP_RESUME, 8'd0, 16'd0, 5'd0);
    send_word(4'd15, 8'd0, 16'd0, 5'd0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 150) calm = 1'b1;
      random_word();
    end
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (NUM_TIMERS + 8) @(posedge clk);
    $display("Sent %0d words over every operation; %0d gets returned an id.",
             sent_count, found_count);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/pets_pkg.sv
rtl/core/pets_fifo.sv
rtl/core/periodic_event_timer_scheduler_top.sv
tb/sv/periodic_event_timer_scheduler_checker.sv
tb/sv/periodic_event_timer_scheduler_top_tb.sv
